/* design/rxfg_pkg.sv */
// Package for the receive FIFO frame collector.
// Holds operation, end-reason and register codes and the configuration struct.
// No dependencies.
package rxfg_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned LEVEL_W = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [2:0] OP_RX    = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_FLUSH = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] END_NONE    = 2'd0;
  localparam logic [1:0] END_MAX_LEN = 2'd1;
  localparam logic [1:0] END_FIRST   = 2'd2;
  localparam logic [1:0] END_GAP     = 2'd3;

  localparam logic [1:0] REG_MAX_LEN = 2'd0;
  localparam logic [1:0] REG_FIRST   = 2'd1;
  localparam logic [1:0] REG_GAP     = 2'd2;

  localparam logic [CNT_W-1:0] RST_MAX_LEN = 16'd64;
  localparam logic [CNT_W-1:0] RST_FIRST   = 16'd1000;
  localparam logic [CNT_W-1:0] RST_GAP     = 16'd10;

  typedef struct packed {
    logic [CNT_W-1:0] max_length;
    logic [CNT_W-1:0] first_byte_timeout;
    logic [CNT_W-1:0] gap_timeout;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

/* design/rxfg_byte_ram.sv */
// Byte store of the receive FIFO: one write port, one registered read port.
// Depends on nothing.
module rxfg_byte_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/rxfg_cfg_regs.sv */
// Configuration registers behind the APB-style port.
// Depends on rxfg_pkg.
module rxfg_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rxfg_pkg::cfg_t      cfg
);
  import rxfg_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length         <= RST_MAX_LEN;
      cfg_r.first_byte_timeout <= RST_FIRST;
      cfg_r.gap_timeout        <= RST_GAP;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAX_LEN: cfg_r.max_length         <= pwdata[CNT_W-1:0];
        REG_FIRST:   cfg_r.first_byte_timeout <= pwdata[CNT_W-1:0];
        REG_GAP:     cfg_r.gap_timeout        <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_LEN: prdata = {16'd0, cfg_r.max_length};
      REG_FIRST:   prdata = {16'd0, cfg_r.first_byte_timeout};
      REG_GAP:     prdata = {16'd0, cfg_r.gap_timeout};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* design/rxfg_ctrl.sv */
// Sequencer of the frame collector: pointers, counters and result register.
// Reads and writes the byte store; depends on rxfg_pkg.
module rxfg_ctrl #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rxfg_pkg::cfg_t       cfg,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_operation,
  input  logic [7:0]           in_rx_byte,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [7:0]           mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [7:0]           mem_rdata,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic                 out_frame_done,
  output logic [1:0]           out_end_reason,
  output logic [15:0]          out_frame_length,
  output logic                 out_dropped,
  output logic [6:0]           out_fifo_level
);
  import rxfg_pkg::*;

  localparam int unsigned LW = (AW > LEVEL_W) ? AW : LEVEL_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  state_t           state_r, state_nxt;
  logic [2:0]       op_r;
  logic [7:0]       rx_r;
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic             coll_r, coll_nxt;
  logic [CNT_W-1:0] cc_r, cc_nxt, wc_r, wc_nxt, ic_r, ic_nxt;

  logic             accept;
  logic             empty, full, done, valid, drop;
  logic [1:0]       reason;
  logic [7:0]       obyte;
  logic [AW:0]      level_sum;
  logic [AW-1:0]    level;
  logic [LW-1:0]    level_x;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_byte_valid_r, out_frame_done_r, out_dropped_r;
  logic [1:0]       out_end_reason_r;
  logic [15:0]      out_frame_length_r;
  logic [6:0]       out_fifo_level_r;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  // issue the store read on acceptance; data arrives in the execute cycle
  assign mem_re    = accept;
  assign mem_raddr = rp_r;
  assign mem_waddr = wp_r;
  assign mem_wdata = rx_r;

  assign empty = (wp_r == rp_r);
  assign full  = (ring_next(wp_r) == rp_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    coll_nxt = coll_r;
    cc_nxt   = cc_r;
    wc_nxt   = wc_r;
    ic_nxt   = ic_r;
    mem_we   = 1'b0;
    done     = 1'b0;
    reason   = END_NONE;
    valid    = 1'b0;
    drop     = 1'b0;
    obyte    = 8'd0;
    if (busy) begin
      case (op_r)
        OP_RX: begin
          if (!full) begin
            mem_we = 1'b1;
            wp_nxt = ring_next(wp_r);
          end else begin
            drop = 1'b1;
          end
        end
        OP_TICK: begin
          if (coll_r) begin
            if (cc_r >= cfg.max_length) begin
              done   = 1'b1;
              reason = END_MAX_LEN;
            end else if (empty) begin
              if (cc_r == '0) begin
                wc_nxt = sat_inc(wc_r);
                if (wc_nxt >= cfg.first_byte_timeout) begin
                  done   = 1'b1;
                  reason = END_FIRST;
                end
              end else begin
                ic_nxt = sat_inc(ic_r);
                if (ic_nxt >= cfg.gap_timeout) begin
                  done   = 1'b1;
                  reason = END_GAP;
                end
              end
            end
          end
        end
        OP_FLUSH: rp_nxt = wp_r;
        OP_START: begin
          coll_nxt = 1'b1;
          cc_nxt   = '0;
          wc_nxt   = '0;
          ic_nxt   = '0;
          if (cfg.max_length == '0) begin
            done   = 1'b1;
            reason = END_MAX_LEN;
          end
        end
        OP_READ: begin
          if (coll_r && (cc_r >= cfg.max_length)) begin
            done   = 1'b1;
            reason = END_MAX_LEN;
          end else if (!empty) begin
            obyte  = mem_rdata;
            rp_nxt = ring_next(rp_r);
            valid  = 1'b1;
            if (coll_r) begin
              cc_nxt = sat_inc(cc_r);
              ic_nxt = '0;
              if (cc_nxt >= cfg.max_length) begin
                done   = 1'b1;
                reason = END_MAX_LEN;
              end
            end
          end
        end
        default: ;
      endcase
      if (done) coll_nxt = 1'b0;
    end
  end

  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      level_sum = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      level_sum = {1'b0, wp_nxt} + DEPTH_X - {1'b0, rp_nxt};
    end
    level   = level_sum[AW-1:0];
    level_x = LW'(level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      coll_r      <= 1'b0;
      cc_r        <= '0;
      wc_r        <= '0;
      ic_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      coll_r      <= coll_nxt;
      cc_r        <= cc_nxt;
      wc_r        <= wc_nxt;
      ic_r        <= ic_nxt;
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      rx_r <= in_rx_byte;
    end
    if (busy) begin
      out_byte_r         <= obyte;
      out_byte_valid_r   <= valid;
      out_frame_done_r   <= done;
      out_end_reason_r   <= reason;
      out_frame_length_r <= cc_nxt;
      out_dropped_r      <= drop;
      out_fifo_level_r   <= level_x[LEVEL_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_valid   = out_byte_valid_r;
  assign out_frame_done   = out_frame_done_r;
  assign out_end_reason   = out_end_reason_r;
  assign out_frame_length = out_frame_length_r;
  assign out_dropped      = out_dropped_r;
  assign out_fifo_level   = out_fifo_level_r;

endmodule

/* design/rx_fifo_gap_frame_collector_core.sv */
// Receive FIFO with frame collection: top level.
// The result strobe is high in the cycle after the execute cycle.
// A new word is not accepted while busy; the execute cycle waits on the byte store read.
// busy is high for the execute cycle only; the receiver cannot stall the result strobe.
// Reset (rst_n low, synchronous) empties the FIFO, ends any collection, loads defaults.
// Depends on rxfg_pkg, rxfg_cfg_regs, rxfg_byte_ram and rxfg_ctrl.
module rx_fifo_gap_frame_collector_core #(
  parameter int unsigned FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_done,
  output logic [1:0]  out_end_reason,
  output logic [15:0] out_frame_length,
  output logic        out_dropped,
  output logic [6:0]  out_fifo_level
);
  import rxfg_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  cfg_t          cfg;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  rxfg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rxfg_byte_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rxfg_ctrl #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_rx_byte       (in_rx_byte),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_done   (out_frame_done),
    .out_end_reason   (out_end_reason),
    .out_frame_length (out_frame_length),
    .out_dropped      (out_dropped),
    .out_fifo_level   (out_fifo_level)
  );

endmodule

/* sim/tb_rx_fifo_gap_frame_collector_core.sv */
// Testbench for rx_fifo_gap_frame_collector_core: directed and random words against a
// behavioural predictor of the receive FIFO and its frame collector.
// Depends on rxfg_pkg and the core RTL; registers are set through the APB-style port.
module tb_rx_fifo_gap_frame_collector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rxfg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0]       data;
    logic             data_ok;
    logic             done;
    logic [1:0]       reason;
    logic [CNT_W-1:0] length;
    logic             drop;
    logic [LEVEL_W-1:0] level;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_operation = OP_TICK;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_frame_done;
  logic [1:0]  out_end_reason;
  logic [15:0] out_frame_length;
  logic        out_dropped;
  logic [6:0]  out_fifo_level;

  rx_fifo_gap_frame_collector_core dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_operation(in_operation), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_frame_done(out_frame_done), .out_end_reason(out_end_reason),
    .out_frame_length(out_frame_length), .out_dropped(out_dropped),
    .out_fifo_level(out_fifo_level)
  );

  // collector model
  cfg_t               model_cfg;
  logic [7:0]         ring_mem [0:127];
  logic [LEVEL_W-1:0] wr_idx;
  logic [LEVEL_W-1:0] rd_idx;
  logic               in_frame;
  logic [CNT_W-1:0]   frame_cnt;
  logic [CNT_W-1:0]   first_wait;
  logic [CNT_W-1:0]   gap_idle;

  status_t     expected_status [$];
  bit          idle_on = 1'b1;
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  int unsigned drops_seen = 0;
  int unsigned ends_by_reason [4] = '{0, 0, 0, 0};

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, expected_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic status_t apply_word(input logic [2:0] op, input logic [7:0] rx);
    status_t            s;
    logic [LEVEL_W-1:0] nxt;
    s = '0;
    case (op)
      OP_RX: begin
        nxt = wr_idx + 1'b1;
        if (nxt != rd_idx) begin
          ring_mem[wr_idx] = rx;
          wr_idx = nxt;
        end else begin
          s.drop = 1'b1;
        end
      end
      OP_TICK: begin
        if (in_frame) begin
          if (frame_cnt >= model_cfg.max_length) begin
            s.done = 1'b1;
            s.reason = END_MAX_LEN;
          end else if (wr_idx == rd_idx) begin
            if (frame_cnt == '0) begin
              first_wait = sat_inc(first_wait);
              if (first_wait >= model_cfg.first_byte_timeout) begin
                s.done = 1'b1;
                s.reason = END_FIRST;
              end
            end else begin
              gap_idle = sat_inc(gap_idle);
              if (gap_idle >= model_cfg.gap_timeout) begin
                s.done = 1'b1;
                s.reason = END_GAP;
              end
            end
          end
        end
      end
      OP_FLUSH: rd_idx = wr_idx;
      OP_START: begin
        in_frame = 1'b1;
        frame_cnt = '0;
        first_wait = '0;
        gap_idle = '0;
        if (model_cfg.max_length == '0) begin
          s.done = 1'b1;
          s.reason = END_MAX_LEN;
        end
      end
      OP_READ: begin
        if (in_frame && frame_cnt >= model_cfg.max_length) begin
          s.done = 1'b1;
          s.reason = END_MAX_LEN;
        end else if (rd_idx != wr_idx) begin
          s.data = ring_mem[rd_idx];
          s.data_ok = 1'b1;
          rd_idx = rd_idx + 1'b1;
          if (in_frame) begin
            frame_cnt = sat_inc(frame_cnt);
            gap_idle = '0;
            if (frame_cnt >= model_cfg.max_length) begin
              s.done = 1'b1;
              s.reason = END_MAX_LEN;
            end
          end
        end
      end
      default: ;
    endcase
    if (s.done) in_frame = 1'b0;
    s.length = frame_cnt;
    s.level = wr_idx - rd_idx;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : status_check
    status_t want;
    if (rst_n && out_valid) begin
      if (expected_status.size() == 0) begin
        err_count++;
        $display("%0t unexpected result word: expected none, actual length %0h level %0h",
                 $time, out_frame_length, out_fifo_level);
      end else begin
        want = expected_status.pop_front();
        check_field("out_byte", 16'(want.data), 16'(out_byte));
        check_field("out_byte_valid", 16'(want.data_ok), 16'(out_byte_valid));
        check_field("out_frame_done", 16'(want.done), 16'(out_frame_done));
        check_field("out_end_reason", 16'(want.reason), 16'(out_end_reason));
        check_field("out_frame_length", want.length, out_frame_length);
        check_field("out_dropped", 16'(want.drop), 16'(out_dropped));
        check_field("out_fifo_level", 16'(want.level), 16'(out_fifo_level));
        if (want.done) ends_by_reason[want.reason]++;
        if (want.drop) drops_seen++;
      end
    end
  end

  task automatic send_word(input logic [2:0] op, input logic [7:0] rx);
    int unsigned gap;
    if (idle_on && $urandom_range(99) < 16) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_rx_byte <= rx;
    do @(posedge clk); while (busy);
    expected_status.push_back(apply_word(op, rx));
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CNT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_LEN: model_cfg.max_length = value;
      REG_FIRST:   model_cfg.first_byte_timeout = value;
      default:     model_cfg.gap_timeout = value;
    endcase
  endtask

  task automatic set_limits(input logic [CNT_W-1:0] max_len, input logic [CNT_W-1:0] first,
                            input logic [CNT_W-1:0] gap);
    drain();
    cfg_write(REG_MAX_LEN, max_len);
    cfg_write(REG_FIRST, first);
    cfg_write(REG_GAP, gap);
  endtask

  function automatic logic [CNT_W-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 18) return CNT_MAX;
    if (r < 80) return CNT_W'($urandom_range(1, 6));
    return CNT_W'($urandom_range(7, 40));
  endfunction

  task automatic test_directed_basics();
    set_limits(16'd3, 16'd2, 16'd2);
    send_word(3'd7, 8'hFF);
    send_word(OP_READ, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_RX, 8'h00);
    send_word(OP_RX, 8'hFF);
    send_word(OP_READ, 8'h00);
    send_word(OP_READ, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_RX, 8'hA5);
    send_word(OP_READ, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_RX, 8'h01);
    send_word(OP_RX, 8'h02);
    send_word(OP_RX, 8'h03);
    send_word(OP_READ, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_READ, 8'h00);
    send_word(OP_READ, 8'h00);
    send_word(OP_FLUSH, 8'h00);
    send_word(OP_READ, 8'h00);
  endtask

  task automatic test_zero_limits();
    set_limits(16'd0, 16'd0, 16'd0);
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    set_limits(16'd5, 16'd0, 16'd0);
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_RX, 8'h3C);
    send_word(OP_TICK, 8'h00);
    send_word(OP_READ, 8'h00);
    send_word(OP_TICK, 8'h00);
  endtask

  task automatic test_max_lowered();
    set_limits(16'd10, 16'd100, 16'd100);
    send_word(OP_START, 8'h00);
    send_word(OP_RX, 8'h11);
    send_word(OP_RX, 8'h22);
    send_word(OP_READ, 8'h00);
    send_word(OP_READ, 8'h00);
    set_limits(16'd1, 16'd100, 16'd100);
    send_word(OP_READ, 8'h00);
    set_limits(16'd10, 16'd100, 16'd100);
    send_word(OP_START, 8'h00);
    send_word(OP_RX, 8'h33);
    send_word(OP_RX, 8'h44);
    send_word(OP_READ, 8'h00);
    set_limits(16'd1, 16'd100, 16'd100);
    send_word(OP_TICK, 8'h00);
    send_word(OP_READ, 8'h00);
  endtask

  task automatic test_fifo_full();
    set_limits(CNT_MAX, CNT_MAX, CNT_MAX);
    send_word(OP_START, 8'h00);
    repeat (131) send_word(OP_RX, 8'($urandom_range(255)));
    send_word(OP_TICK, 8'h00);
    repeat (129) send_word(OP_READ, 8'h00);
    repeat (3) send_word(OP_TICK, 8'h00);
    repeat (5) send_word(OP_RX, 8'($urandom_range(255)));
    send_word(OP_FLUSH, 8'h00);
    send_word(OP_READ, 8'h00);
  endtask

  task automatic test_random_traffic();
    int unsigned r;
    for (int phase = 0; phase < 14; phase++) begin
      idle_on = (phase != 3);
      set_limits(pick_limit(), pick_limit(), pick_limit());
      send_word(OP_START, 8'h00);
      repeat (60) begin
        r = $urandom_range(99);
        if (r < 30)      send_word(OP_RX, 8'($urandom_range(255)));
        else if (r < 57) send_word(OP_READ, 8'($urandom_range(255)));
        else if (r < 84) send_word(OP_TICK, 8'($urandom_range(255)));
        else if (r < 90) send_word(OP_START, 8'($urandom_range(255)));
        else if (r < 94) send_word(OP_FLUSH, 8'($urandom_range(255)));
        else if (r < 97) send_word(3'($urandom_range(5, 7)), 8'($urandom_range(255)));
        else             send_word(3'($urandom_range(7)), 8'($urandom_range(255)));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    model_cfg = '{max_length: RST_MAX_LEN, first_byte_timeout: RST_FIRST,
                  gap_timeout: RST_GAP};
    wr_idx = '0;
    rd_idx = '0;
    in_frame = 1'b0;
    frame_cnt = '0;
    first_wait = '0;
    gap_idle = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_basics();
    test_zero_limits();
    test_max_lowered();
    test_fifo_full();
    test_random_traffic();
    drain();
    $display("Sent %0d words; frame ends by max length %0d, first byte %0d, gap %0d",
             words_sent, ends_by_reason[END_MAX_LEN], ends_by_reason[END_FIRST],
             ends_by_reason[END_GAP]);
    $display("Dropped bytes on a full FIFO: %0d; zero and full-scale limits included",
             drops_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
design/rxfg_pkg.sv
design/rxfg_byte_ram.sv
design/rxfg_cfg_regs.sv
design/rxfg_ctrl.sv
design/rx_fifo_gap_frame_collector_core.sv
sim/tb_rx_fifo_gap_frame_collector_core.sv
